// File: hdl/jacobi_7point_stencil_3d_defines.svh
// ----------------------------------------------------------------------------
// jacobi_7point_stencil_3d_defines
// assertion macros shared by the stencil checker
// ----------------------------------------------------------------------------
`ifndef JACOBI_7POINT_STENCIL_3D_DEFINES_SVH
`define JACOBI_7POINT_STENCIL_3D_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define JAC3D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JAC3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/jac3d_pkg.sv
// ----------------------------------------------------------------------------
// jac3d_pkg
// shared types, constants and the divide-by-six step for the stencil
// ----------------------------------------------------------------------------
`default_nettype none

package jac3d_pkg;

  // geometry and word sizes
  localparam int MAX_EDGE_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int GRID_W       = 8;
  localparam logic [GRID_W-1:0] GRID_RESET = 8'd128;
  localparam int MIN_EDGE     = 3;
  localparam int QUEUE_DEPTH  = 4;

  // mean of six: (sum + 3) / 6, long division seven bits per stage
  localparam int DIV_BITS   = 7;
  localparam int DIV_STAGES = 5;
  localparam int SUM_W      = DIV_BITS * DIV_STAGES;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 35'd3;
  localparam logic [3:0] DIVISOR = 4'd6;

  // input word kinds
  typedef enum logic {
    KIND_CELL  = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  // control that travels with each queued word
  typedef struct packed {
    logic first;
    logic emit;
    logic boundary;
    logic last;
  } ctl_t;

  // DIV_BITS steps of restoring division by six, remainder below six
  function automatic logic [DIV_BITS+2:0] div6_step(input logic [2:0] rem_in,
                                                    input logic [DIV_BITS-1:0] bits);
    logic [3:0]          r;
    logic [DIV_BITS-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int b = DIV_BITS - 1; b >= 0; b--) begin
      r = {r[2:0], bits[b]};
      if (r >= DIVISOR) begin
        q[b] = 1'b1;
        r    = r - DIVISOR;
      end
    end
    return {r[2:0], q};
  endfunction

endpackage

`default_nettype wire

// File: hdl/jacobi_7point_stencil_3d.sv
// Throughput: one word per cycle while the queue and output do not stall.
// Five delay lines advance once for each word popped from the queue.
// Output trails input by one plane plus one row plus one cell; flush words drain it.
// Reset (rst_n low, synchronous): edge register to 128, positions and valid bits cleared.
// Line memories need no clearing: every entry read for an interior cell is fresh.
// ----------------------------------------------------------------------------
// jacobi_7point_stencil_3d
// streaming 3d jacobi sweep, seven-point stencil, when not stalled one cell per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_7point_stencil_3d #(
  parameter int MAX_EDGE = jac3d_pkg::MAX_EDGE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration: grid_size
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [jac3d_pkg::GRID_W-1:0] cfg_data,
  // input words
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [jac3d_pkg::DATA_W-1:0] in_tdata,   // [31:0] cell_value
  input  wire logic                         in_tuser,   // [0] kind
  // result words
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [jac3d_pkg::DATA_W-1:0]      out_tdata,  // [31:0] new_value
  output logic                              out_tlast   // last_of_sweep
);

  localparam int EW = $clog2(MAX_EDGE + 1);
  localparam int CTW = $bits(jac3d_pkg::ctl_t);
  localparam int QW = EW + CTW + jac3d_pkg::DATA_W;

  logic                         push, q_full, q_pop, q_valid;
  jac3d_pkg::ctl_t              push_ctl, q_ctl;
  logic [EW-1:0]                push_n, q_n;
  logic [jac3d_pkg::DATA_W-1:0] push_data, q_data;
  logic [QW-1:0]                q_in, q_out;

  assign cfg_ready = 1'b1;

  // front: classify and track positions
  jac3d_front #(.MAX_EDGE(MAX_EDGE), .EW(EW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .in_cell   (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_n    (push_n),
    .push_data (push_data)
  );

  // queue between front and back
  assign q_in = {push_n, push_ctl, push_data};

  jac3d_fifo #(.W(QW), .DEPTH(jac3d_pkg::QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign q_n    = q_out[QW-1 -: EW];
  assign q_ctl  = jac3d_pkg::ctl_t'(q_out[jac3d_pkg::DATA_W +: CTW]);
  assign q_data = q_out[jac3d_pkg::DATA_W-1:0];

  // back: window, sum, mean
  jac3d_back #(.MAX_EDGE(MAX_EDGE), .EW(EW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_n        (q_n),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: hdl/jac3d_fifo.sv
// ----------------------------------------------------------------------------
// jac3d_fifo
// short register queue between the classifying front and the stencil back
// ----------------------------------------------------------------------------
`default_nettype none

module jac3d_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = jac3d_pkg::QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rptr_r];

  // pointer and fill count
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/jac3d_front.sv
// ----------------------------------------------------------------------------
// jac3d_front
// takes words, tracks input and output positions, classifies each word
// ----------------------------------------------------------------------------
`default_nettype none

module jac3d_front #(
  parameter int MAX_EDGE = jac3d_pkg::MAX_EDGE_DEF,
  parameter int EW       = $clog2(MAX_EDGE + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [jac3d_pkg::GRID_W-1:0]  cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic                          in_kind,
  input  wire logic [jac3d_pkg::DATA_W-1:0]  in_cell,
  input  wire logic                          q_full,
  output logic                               push,
  output jac3d_pkg::ctl_t                    push_ctl,
  output logic [EW-1:0]                      push_n,
  output logic [jac3d_pkg::DATA_W-1:0]       push_data
);

  localparam int CW = $clog2(MAX_EDGE);
  localparam logic [8:0] MAX9 = 9'(MAX_EDGE);
  localparam logic [8:0] MIN9 = 9'(jac3d_pkg::MIN_EDGE);

  logic [jac3d_pkg::GRID_W-1:0] grid_r;
  logic [EW-1:0] edge_r, edge_nxt;
  logic [CW-1:0] ii_r, jj_r, kk_r, ii_nxt, jj_nxt, kk_nxt;
  logic [CW-1:0] oi_r, oj_r, ok_r, oi_nxt, oj_nxt, ok_nxt;
  logic          all_in_r, all_in_nxt;
  logic          emitting_r, emitting_nxt;

  logic [8:0]    g9, n9;
  logic [EW-1:0] n_use;
  logic [CW-1:0] nm1;
  logic          acc, is_cell, sweep_idle, take_cell, take_flush;
  logic          in_last, emit_cell, emit, out_last, out_bnd;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= jac3d_pkg::GRID_RESET;
    end else if (cfg_valid) begin
      grid_r <= cfg_data;
    end
  end

  // edge in use: clamped register at sweep start, latched value otherwise
  always_comb begin
    g9 = {1'b0, grid_r};
    if (g9 < MIN9) begin
      n9 = MIN9;
    end else if (g9 > MAX9) begin
      n9 = MAX9;
    end else begin
      n9 = g9;
    end
  end

  assign sweep_idle = (ii_r == '0) && (jj_r == '0) && (kk_r == '0) && !all_in_r;
  assign n_use      = sweep_idle ? EW'(n9) : edge_r;
  assign nm1        = CW'(n_use - EW'(1));

  // classification
  assign in_tready  = !q_full;
  assign acc        = in_tvalid && in_tready;
  assign is_cell    = (jac3d_pkg::kind_t'(in_kind) == jac3d_pkg::KIND_CELL);
  assign take_cell  = acc && is_cell && !all_in_r;
  assign take_flush = acc && !is_cell && all_in_r;
  assign in_last    = (ii_r == nm1) && (jj_r == nm1) && (kk_r == nm1);
  assign emit_cell  = emitting_r ||
                      ((ii_r == CW'(1)) && (jj_r == CW'(1)) && (kk_r == CW'(1)));
  assign emit       = take_flush || (take_cell && emit_cell);
  assign out_last   = (oi_r == nm1) && (oj_r == nm1) && (ok_r == nm1);
  assign out_bnd    = (oi_r == '0) || (oi_r == nm1) || (oj_r == '0) || (oj_r == nm1) ||
                      (ok_r == '0) || (ok_r == nm1);

  // queue word
  assign push              = take_cell || take_flush;
  assign push_ctl.first    = take_cell && sweep_idle;
  assign push_ctl.emit     = emit;
  assign push_ctl.boundary = out_bnd;
  assign push_ctl.last     = out_last;
  assign push_n            = n_use;
  assign push_data         = in_cell;

  // position tracking
  always_comb begin
    edge_nxt     = edge_r;
    ii_nxt       = ii_r;
    jj_nxt       = jj_r;
    kk_nxt       = kk_r;
    oi_nxt       = oi_r;
    oj_nxt       = oj_r;
    ok_nxt       = ok_r;
    all_in_nxt   = all_in_r;
    emitting_nxt = emitting_r;
    if (take_cell) begin
      edge_nxt = n_use;
      if (emit_cell) begin
        emitting_nxt = 1'b1;
      end
      if (in_last) begin
        all_in_nxt = 1'b1;
        ii_nxt     = '0;
        jj_nxt     = '0;
        kk_nxt     = '0;
      end else if (kk_r != nm1) begin
        kk_nxt = kk_r + CW'(1);
      end else begin
        kk_nxt = '0;
        if (jj_r != nm1) begin
          jj_nxt = jj_r + CW'(1);
        end else begin
          jj_nxt = '0;
          ii_nxt = ii_r + CW'(1);
        end
      end
    end
    if (emit) begin
      if (ok_r != nm1) begin
        ok_nxt = ok_r + CW'(1);
      end else begin
        ok_nxt = '0;
        if (oj_r != nm1) begin
          oj_nxt = oj_r + CW'(1);
        end else begin
          oj_nxt = '0;
          oi_nxt = oi_r + CW'(1);
        end
      end
      // last cell out ends the sweep
      if (out_last) begin
        ii_nxt       = '0;
        jj_nxt       = '0;
        kk_nxt       = '0;
        oi_nxt       = '0;
        oj_nxt       = '0;
        ok_nxt       = '0;
        all_in_nxt   = 1'b0;
        emitting_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r     <= EW'(MAX_EDGE);
      ii_r       <= '0;
      jj_r       <= '0;
      kk_r       <= '0;
      oi_r       <= '0;
      oj_r       <= '0;
      ok_r       <= '0;
      all_in_r   <= 1'b0;
      emitting_r <= 1'b0;
    end else begin
      edge_r     <= edge_nxt;
      ii_r       <= ii_nxt;
      jj_r       <= jj_nxt;
      kk_r       <= kk_nxt;
      oi_r       <= oi_nxt;
      oj_r       <= oj_nxt;
      ok_r       <= ok_nxt;
      all_in_r   <= all_in_nxt;
      emitting_r <= emitting_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/jac3d_dline.sv
// ----------------------------------------------------------------------------
// jac3d_dline
// variable-length delay line in a circular memory, read before write
// ----------------------------------------------------------------------------
`default_nettype none

module jac3d_dline #(
  parameter int DEPTH = 4,
  parameter int LW    = 8,
  parameter int DW    = jac3d_pkg::DATA_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          first,
  input  wire logic [LW-1:0] len,
  input  wire logic [DW-1:0] din,
  output logic [DW-1:0]      dout
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] ptr_r, ptr_nxt, waddr;
  logic [DW-1:0] dout_r;

  assign waddr = first ? '0 : ptr_r;
  assign dout  = dout_r;

  // pointer wraps at the current line length
  always_comb begin
    if (first) begin
      ptr_nxt = (len == LW'(1)) ? '0 : AW'(1);
    end else if (LW'(ptr_r) == len - LW'(1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (adv) begin
      ptr_r <= ptr_nxt;
    end
  end

  // memory: old word out, new word in
  always_ff @(posedge clk) begin
    if (adv) begin
      dout_r      <= mem[waddr];
      mem[waddr]  <= din;
    end
  end

endmodule

`default_nettype wire

// File: hdl/jac3d_back.sv
// ----------------------------------------------------------------------------
// jac3d_back
// neighbour window from delay lines, six-way sum and pipelined mean
// ----------------------------------------------------------------------------
`default_nettype none

module jac3d_back #(
  parameter int MAX_EDGE = jac3d_pkg::MAX_EDGE_DEF,
  parameter int EW       = $clog2(MAX_EDGE + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire jac3d_pkg::ctl_t              q_ctl,
  input  wire logic [EW-1:0]                q_n,
  input  wire logic [jac3d_pkg::DATA_W-1:0] q_data,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [jac3d_pkg::DATA_W-1:0]      out_tdata,
  output logic                              out_tlast
);

  localparam int LW = 2 * EW;
  localparam int DW = jac3d_pkg::DATA_W;
  localparam int NS = jac3d_pkg::DIV_STAGES;
  localparam int SW = jac3d_pkg::SUM_W;
  localparam int DB = jac3d_pkg::DIV_BITS;

  logic          en;
  logic [LW-1:0] n_ext, nn, len_a, len_b, len_c;
  logic [DW-1:0] t_up, t_pn, t_p1, t_mn, t_mp;
  logic [DW-1:0] c_r, m1_r;
  logic          t_v_r, t_bnd_r, t_last_r;
  logic          s1_v_r, s1_bnd_r, s1_last_r;
  logic [DW:0]   sa_r, sb_r, sc_r;
  logic [DW-1:0] s1_ctr_r;
  logic          d_v_r    [NS+1];
  logic          d_bnd_r  [NS+1];
  logic          d_last_r [NS+1];
  logic [DW-1:0] d_ctr_r  [NS+1];
  logic [SW-1:0] d_q_r    [NS+1];
  logic [SW-1:0] d_y_r    [NS];
  logic [2:0]    d_rem_r  [NS];
  logic [DB+2:0] step_res [NS];
  logic          out_valid_r, out_last_r;
  logic [DW-1:0] out_data_r;

  // whole pipeline holds while the output word waits
  assign en    = !out_valid_r || out_tready;
  assign q_pop = q_valid && en;

  // line lengths for the sweep's edge
  assign n_ext = LW'(q_n);
  assign nn    = n_ext * n_ext;
  assign len_a = n_ext + LW'(1);
  assign len_b = nn - n_ext - LW'(1);
  assign len_c = n_ext - LW'(2);

  // neighbour above in i
  jac3d_dline #(.DEPTH(MAX_EDGE + 1), .LW(LW)) u_line_up (
    .clk(clk), .rst_n(rst_n), .adv(q_pop), .first(q_ctl.first), .len(len_a),
    .din(q_data), .dout(t_up)
  );

  // neighbour above in j
  jac3d_dline #(.DEPTH(MAX_EDGE * MAX_EDGE), .LW(LW)) u_line_pn (
    .clk(clk), .rst_n(rst_n), .adv(q_pop), .first(q_ctl.first), .len(len_b),
    .din(t_up), .dout(t_pn)
  );

  // neighbour above in k
  jac3d_dline #(.DEPTH(MAX_EDGE), .LW(LW)) u_line_p1 (
    .clk(clk), .rst_n(rst_n), .adv(q_pop), .first(q_ctl.first), .len(len_c),
    .din(t_pn), .dout(t_p1)
  );

  // neighbour below in j
  jac3d_dline #(.DEPTH(MAX_EDGE), .LW(LW)) u_line_mn (
    .clk(clk), .rst_n(rst_n), .adv(q_pop), .first(q_ctl.first), .len(len_c),
    .din(m1_r), .dout(t_mn)
  );

  // neighbour below in i
  jac3d_dline #(.DEPTH(MAX_EDGE * MAX_EDGE), .LW(LW)) u_line_mp (
    .clk(clk), .rst_n(rst_n), .adv(q_pop), .first(q_ctl.first), .len(len_b),
    .din(t_mn), .dout(t_mp)
  );

  // centre and neighbour below in k
  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_r  <= t_p1;
      m1_r <= c_r;
    end
  end

  // division steps
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      step_res[k] = jac3d_pkg::div6_step(d_rem_r[k], d_y_r[k][SW-1-k*DB -: DB]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= NS; k++) begin
        d_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      t_v_r       <= q_pop && q_ctl.emit;
      s1_v_r      <= t_v_r;
      d_v_r[0]    <= s1_v_r;
      for (int k = 0; k < NS; k++) begin
        d_v_r[k+1] <= d_v_r[k];
      end
      out_valid_r <= d_v_r[NS];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      t_bnd_r    <= q_ctl.boundary;
      t_last_r   <= q_ctl.last;
      sa_r       <= {1'b0, t_up} + {1'b0, t_mp};
      sb_r       <= {1'b0, t_pn} + {1'b0, t_mn};
      sc_r       <= {1'b0, t_p1} + {1'b0, m1_r};
      s1_ctr_r   <= c_r;
      s1_bnd_r   <= t_bnd_r;
      s1_last_r  <= t_last_r;
      d_y_r[0]   <= SW'(sa_r) + SW'(sb_r) + SW'(sc_r) + jac3d_pkg::ROUND_BIAS;
      d_rem_r[0] <= '0;
      d_q_r[0]   <= '0;
      d_ctr_r[0] <= s1_ctr_r;
      d_bnd_r[0] <= s1_bnd_r;
      d_last_r[0] <= s1_last_r;
      for (int k = 0; k < NS; k++) begin
        d_q_r[k+1]    <= {d_q_r[k][SW-DB-1:0], step_res[k][DB-1:0]};
        d_ctr_r[k+1]  <= d_ctr_r[k];
        d_bnd_r[k+1]  <= d_bnd_r[k];
        d_last_r[k+1] <= d_last_r[k];
        if (k + 1 < NS) begin
          d_y_r[k+1]   <= d_y_r[k];
          d_rem_r[k+1] <= step_res[k][DB+2:DB];
        end
      end
      out_data_r <= d_bnd_r[NS] ? d_ctr_r[NS] : d_q_r[NS][DW-1:0];
      out_last_r <= d_last_r[NS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: hdl/jac3d_checker.sv
// ----------------------------------------------------------------------------
// jac3d_checker
// port-level checks on the stencil, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_7point_stencil_3d_defines.svh"

module jac3d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast
);

  // a stalled result word holds
  `JAC3D_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result word changed while stalled")

  // input is ready straight after reset, the queue being empty
  `JAC3D_ASSERT_NOW(a_ready_after_reset, $past(!rst_n), in_tready, "input not ready after reset")

  // nothing comes out straight after reset
  `JAC3D_ASSERT_NOW(a_no_out_after_reset, $past(!rst_n), !out_tvalid, "result word right after reset")

endmodule

bind jacobi_7point_stencil_3d jac3d_checker u_jac3d_checker (.*);

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the streaming 3d jacobi sweep: whole cubes of small
// edge are streamed in with flush words to drain them, each swept word is
// compared with a model of the stencil, under shifting sender and receiver
// idling
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH = 2 * jac3d_pkg::MAX_EDGE_DEF * jac3d_pkg::MAX_EDGE_DEF
                             + jac3d_pkg::MAX_EDGE_DEF + 2;
  localparam int DRAIN_CYCLES = 16;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [jac3d_pkg::GRID_W-1:0]        cfg_data = '0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [jac3d_pkg::DATA_W-1:0]        in_tdata = '0;
  logic                                in_tuser = jac3d_pkg::KIND_CELL;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [jac3d_pkg::DATA_W-1:0]        out_tdata;
  logic                                out_tlast;

  // typed expectation riding with the word on the input side
  logic                                word_typed = 1'b0;
  logic [jac3d_pkg::DATA_W-1:0]        word_typed_val = '0;

  typedef struct {
    logic [jac3d_pkg::DATA_W-1:0] value;
    logic                         last;
  } swept_t;

  typedef struct {
    jac3d_pkg::kind_t             kind;
    logic [jac3d_pkg::DATA_W-1:0] value;
    int                           reps;
    bit                           typed;
    logic [jac3d_pkg::DATA_W-1:0] typed_val;
  } stim_row_t;

  swept_t      swept_q[$];
  int          errors = 0;
  int          checked = 0;
  int          sweeps_done = 0;
  int          send_idle = 0;
  int          recv_stall = 0;

  // model state
  logic [jac3d_pkg::DATA_W-1:0] cube_win [WIN_DEPTH];
  int unsigned                  cells_in = 0;
  int unsigned                  cells_out = 0;
  logic [jac3d_pkg::GRID_W-1:0] grid_reg = jac3d_pkg::GRID_RESET;
  int unsigned                  edge_n = jac3d_pkg::MAX_EDGE_DEF;

  jacobi_7point_stencil_3d dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  function automatic int unsigned clamp_edge(input logic [jac3d_pkg::GRID_W-1:0] g);
    if (g < jac3d_pkg::MIN_EDGE) return jac3d_pkg::MIN_EDGE;
    if (g > jac3d_pkg::MAX_EDGE_DEF) return jac3d_pkg::MAX_EDGE_DEF;
    return g;
  endfunction

  function automatic logic [jac3d_pkg::DATA_W-1:0] win_rd(input int unsigned c);
    return cube_win[c % WIN_DEPTH];
  endfunction

  // next swept cell from the window
  function automatic swept_t sweep_cell();
    int unsigned n, pl, total, p, i, j, k;
    logic [jac3d_pkg::SUM_W-1:0] sum;
    swept_t r;
    n = edge_n; pl = n * n; total = pl * n; p = cells_out;
    i = p / pl; j = (p / n) % n; k = p % n;
    if (i == 0 || i == n - 1 || j == 0 || j == n - 1 || k == 0 || k == n - 1) begin
      r.value = win_rd(p);
    end else begin
      sum = jac3d_pkg::SUM_W'(win_rd(p - pl)) + win_rd(p + pl) + win_rd(p - n)
          + win_rd(p + n) + win_rd(p - 1) + win_rd(p + 1);
      r.value = jac3d_pkg::DATA_W'((sum + 3) / 6);
    end
    r.last = (p == total - 1);
    cells_out = p + 1;
    if (cells_out >= total) begin
      cells_in = 0;
      cells_out = 0;
    end
    return r;
  endfunction

  // one accepted word; returns 1 when it releases a swept cell
  function automatic bit stencil_step(input jac3d_pkg::kind_t k,
                                      input logic [jac3d_pkg::DATA_W-1:0] v,
                                      output swept_t r);
    int unsigned total, lag;
    if (cells_in == 0 && cells_out == 0) edge_n = clamp_edge(grid_reg);
    total = edge_n * edge_n * edge_n;
    lag = edge_n * edge_n + edge_n + 1;
    if (k == jac3d_pkg::KIND_FLUSH) begin
      if (cells_in >= total && cells_out < total) begin
        r = sweep_cell();
        return 1;
      end
      return 0;
    end
    if (cells_in >= total) return 0;
    cube_win[cells_in % WIN_DEPTH] = v;
    cells_in++;
    if (cells_in > lag) begin
      r = sweep_cell();
      return 1;
    end
    return 0;
  endfunction

  // input/config monitor and result checker
  always @(posedge clk) begin
    swept_t e, r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (swept_q.size() == 0) begin
          $display("%0t: unexpected word value %h last %b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          e = swept_q.pop_front();
          checked++;
          if (out_tdata !== e.value) begin
            $display("%0t: value expected %h actual %h", $time, e.value, out_tdata);
            errors++;
          end
          if (out_tlast !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, out_tlast);
            errors++;
          end
          if (e.last) sweeps_done++;
        end
      end
      if (cfg_valid && cfg_ready) grid_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        if (stencil_step(jac3d_pkg::kind_t'(in_tuser), in_tdata, r)) begin
          if (word_typed) r.value = word_typed_val;
          swept_q.push_back(r);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  task automatic send_word(input jac3d_pkg::kind_t k,
                           input logic [jac3d_pkg::DATA_W-1:0] v,
                           input bit typed, input logic [jac3d_pkg::DATA_W-1:0] tv);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= v;
    word_typed <= typed;
    word_typed_val <= tv;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (swept_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_grid(input logic [jac3d_pkg::GRID_W-1:0] g);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [jac3d_pkg::DATA_W-1:0] rand_cell();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one whole cube with random content and a little noise
  task automatic run_sweep(input int unsigned n, input bit pause_mid);
    int unsigned total, lag;
    total = n * n * n;
    lag = n * n + n + 1;
    for (int unsigned c = 0; c < total; c++) begin
      if ($urandom_range(99) < 4) send_word(jac3d_pkg::KIND_FLUSH, $urandom, 0, '0);
      if (pause_mid && c == total / 2) hold_until_drained();
      send_word(jac3d_pkg::KIND_CELL, rand_cell(), 0, '0);
    end
    for (int unsigned d = 0; d < lag; d++) begin
      if ($urandom_range(99) < 4) send_word(jac3d_pkg::KIND_CELL, rand_cell(), 0, '0);
      send_word(jac3d_pkg::KIND_FLUSH, $urandom, 0, '0);
    end
    if ($urandom_range(1)) send_word(jac3d_pkg::KIND_FLUSH, $urandom, 0, '0);
  endtask

  // directed 3-cube of full-scale cells: every swept word is full scale
  stim_row_t directed_rows[5] = '{
    '{jac3d_pkg::KIND_FLUSH, 32'h0,        1,  1'b0, 32'h0},
    '{jac3d_pkg::KIND_CELL,  32'hFFFFFFFF, 27, 1'b1, 32'hFFFFFFFF},
    '{jac3d_pkg::KIND_CELL,  32'h0,        1,  1'b0, 32'h0},
    '{jac3d_pkg::KIND_FLUSH, 32'h0,        13, 1'b1, 32'hFFFFFFFF},
    '{jac3d_pkg::KIND_FLUSH, 32'hFFFFFFFF, 1,  1'b0, 32'h0}
  };

  logic [jac3d_pkg::GRID_W-1:0] grid_plan[7] = '{8'd0, 8'd4, 8'd5, 8'd1, 8'd6, 8'd3, 8'd2};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_grid(8'd3);
    foreach (directed_rows[r])
      for (int n = 0; n < directed_rows[r].reps; n++)
        send_word(directed_rows[r].kind, directed_rows[r].value,
                  directed_rows[r].typed, directed_rows[r].typed_val);

    foreach (grid_plan[s]) begin
      write_grid(grid_plan[s]);
      case (s % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 34; recv_stall = 34; end
      endcase
      run_sweep(clamp_edge(grid_plan[s]), s == 2);
    end

    // largest edge: only the start of the cube, nothing leaves yet
    write_grid(8'd255);
    send_idle = 0; recv_stall = 0;
    for (int c = 0; c < 120; c++) send_word(jac3d_pkg::KIND_CELL, rand_cell(), 0, '0);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d full sweeps, edges 3 to 6 plus clamped and largest edges",
             sweeps_done);
    $display("%0d swept words checked, %0d mismatches", checked, errors);
    if (errors == 0 && swept_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout waiting on the stencil");
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
